[design/lsa_pkg.sv]
// Shared types, constants and helper functions of the Lorentzian spectrum accumulator.
// No dependencies; imported by lsa_front, lsa_back and the top level.
`default_nettype none
package lsa_pkg;

	localparam int NUM_BINS_DEF = 128;
	localparam logic [48:0] PREF_Q64 = 49'd424752677400000;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INCIDENT = 3'd0,
		CFG_CORE_BRD = 3'd1,
		CFG_FINAL_BRD = 3'd2,
		CFG_SCALE = 3'd3,
		CFG_STEP = 3'd4
	} cfg_idx_t;

	typedef enum logic {
		CMD_ACCUM = 1'b0,
		CMD_READ = 1'b1
	} cmd_t;

	typedef struct packed {
		logic command;
		logic signed [31:0] lower_energy;
		logic signed [31:0] upper_energy;
		logic signed [31:0] weight;
		logic [6:0] bin_index;
	} item_t;

	typedef struct packed {
		logic signed [63:0] bin_sum;
		logic [31:0] loss_energy;
	} result_t;

	typedef struct packed {
		logic signed [31:0] incident_energy;
		logic [30:0] core_broadening;
		logic [30:0] final_broadening;
		logic signed [31:0] energy_scale;
		logic [30:0] bin_step;
	} cfg_t;

	// front to back request channel
	typedef struct packed {
		logic valid;
		item_t item;
	} req_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > 66'sh7FFFFFFF)
			r = 32'sh7FFFFFFF;
		else if (v < -66'sh80000000)
			r = -32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		logic [31:0] r;
		r = v[31] ? 32'(-v) : 32'(v);
		return r;
	endfunction

endpackage
`default_nettype wire

[design/lsa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lsa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[design/lsa_front.sv]
// Input queue: accepts requests and holds them for the back end (two entries).
// Depends on lsa_pkg.
`default_nettype none
module lsa_front import lsa_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire item_t item,
	output req_t req,
	input wire logic req_pop
);
	item_t ent_q [2];
	logic wptr_q, rptr_q;
	logic [1:0] cnt_q;
	logic do_push, do_pop;

	assign full = (cnt_q == 2'd2);
	assign do_push = push && !full;
	assign do_pop = req_pop && (cnt_q != 2'd0);
	assign req.valid = (cnt_q != 2'd0);
	assign req.item = ent_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			ent_q[wptr_q] <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push)
				wptr_q <= !wptr_q;
			if (do_pop)
				rptr_q <= !rptr_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end
endmodule
`default_nettype wire

[design/lsa_div.sv]
// Restoring divider, 128-bit dividend by 64-bit divisor below 2^63, two bits a cycle.
// No dependencies.
`default_nettype none
module lsa_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [127:0] num,
	input wire logic [63:0] den,
	output logic busy,
	output logic done,
	output logic [127:0] quo
);
	logic [63:0] rem_q, den_q;
	logic [127:0] quo_q;
	logic [5:0] cnt_q;
	logic busy_q, done_q;
	logic [64:0] r1, r2;
	logic ge1, ge2;
	logic [63:0] r1n, r2n;
	logic [127:0] q1, q2;

	always_comb begin
		r1 = {rem_q, quo_q[127]};
		ge1 = (r1 >= {1'b0, den_q});
		r1n = ge1 ? 64'(r1 - {1'b0, den_q}) : r1[63:0];
		q1 = {quo_q[126:0], ge1};
		r2 = {r1n, q1[127]};
		ge2 = (r2 >= {1'b0, den_q});
		r2n = ge2 ? 64'(r2 - {1'b0, den_q}) : r2[63:0];
		q2 = {q1[126:0], ge2};
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo = quo_q;

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= r2n;
			quo_q <= q2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

[design/lsa_back.sv]
// Back end: sequencer with shared multiplier and divider, bin store and result register.
// Depends on lsa_pkg, lsa_div and lsa_ram.
`default_nettype none
module lsa_back import lsa_pkg::*; #(
	parameter int NUM_BINS = NUM_BINS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire cfg_t cfg,
	input wire req_t req,
	output logic req_pop,
	output logic empty,
	input wire logic pop,
	output result_t result
);
	localparam int AW = $clog2(NUM_BINS);

	typedef enum logic [13:0] {
		S_IDLE = 14'b00000000000001,
		S_M1 = 14'b00000000000010,
		S_M2 = 14'b00000000000100,
		S_M3 = 14'b00000000001000,
		S_M4 = 14'b00000000010000,
		S_M5 = 14'b00000000100000,
		S_M6 = 14'b00000001000000,
		S_M7 = 14'b00000010000000,
		S_PP = 14'b00000100000000,
		S_D1 = 14'b00001000000000,
		S_D1W = 14'b00010000000000,
		S_BE = 14'b00100000000000,
		S_BD = 14'b01000000000000,
		S_BW = 14'b10000000000000
	} st_t;

	st_t st_q;
	logic rd_q, rd2_q;
	item_t it_q;
	logic signed [32:0] ma, mb;
	logic signed [65:0] prod_q;
	logic signed [31:0] a_q, d_q;
	logic [63:0] d1_q, hh_q;
	logic [62:0] p_q;
	logic [2:0] pp_q;
	logic [127:0] num_q;
	logic [AW-1:0] k_q;
	logic [41:0] kstep_q;
	logic [NUM_BINS-1:0] vld_q;
	logic out_vld_q;
	result_t out_q;

	logic [30:0] g, h;
	logic signed [32:0] ediff;
	logic signed [31:0] e;
	logic div_start, div_busy, div_done;
	logic [127:0] div_num, div_quo;
	logic [63:0] div_den;
	logic ram_we, ram_re;
	logic [AW-1:0] ram_raddr;
	logic [63:0] ram_rdata, ram_wdata;
	logic [63:0] tmag;
	logic signed [63:0] term, old;
	logic signed [64:0] s65;
	logic rd_in_range;
	logic [AW-1:0] rd_addr;
	logic [37:0] loss_full;
	logic res_load;
	logic [127:0] pp_add;

	assign g = (cfg.core_broadening == '0) ? 31'd1 : cfg.core_broadening;
	assign h = (cfg.final_broadening == '0) ? 31'd1 : cfg.final_broadening;
	assign ediff = 33'(it_q.upper_energy) - 33'(it_q.lower_energy);
	assign e = sat32(66'(d_q) - $signed({24'd0, kstep_q}));
	assign rd_in_range = 32'(it_q.bin_index) < 32'(NUM_BINS);
	assign rd_addr = AW'(it_q.bin_index);
	assign loss_full = 38'(it_q.bin_index) * 38'(cfg.bin_step);

	always_comb begin
		ma = '0;
		mb = '0;
		unique case (st_q)
			S_M1: begin
				ma = 33'(cfg.energy_scale);
				mb = 33'(it_q.upper_energy);
			end
			S_M2: begin
				ma = 33'(cfg.energy_scale);
				mb = ediff;
			end
			S_M3: begin
				ma = $signed({1'b0, mag32(a_q)});
				mb = $signed({1'b0, mag32(a_q)});
			end
			S_M4: begin
				ma = $signed({2'b0, g});
				mb = $signed({2'b0, g});
			end
			S_M5: begin
				ma = $signed({2'b0, h});
				mb = $signed({2'b0, h});
			end
			S_M6: begin
				ma = $signed({1'b0, mag32(it_q.weight)});
				mb = $signed({2'b0, h});
			end
			S_PP: begin
				unique case (pp_q)
					3'd0: begin
						ma = $signed({1'b0, p_q[31:0]});
						mb = $signed({1'b0, PREF_Q64[31:0]});
					end
					3'd1: begin
						ma = $signed({1'b0, p_q[31:0]});
						mb = $signed({16'd0, PREF_Q64[48:32]});
					end
					3'd2: begin
						ma = $signed({2'b0, p_q[62:32]});
						mb = $signed({1'b0, PREF_Q64[31:0]});
					end
					3'd3: begin
						ma = $signed({2'b0, p_q[62:32]});
						mb = $signed({16'd0, PREF_Q64[48:32]});
					end
					default: begin
						ma = '0;
						mb = '0;
					end
				endcase
			end
			S_BE: begin
				ma = $signed({1'b0, mag32(e)});
				mb = $signed({1'b0, mag32(e)});
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	always_comb begin
		unique case (pp_q)
			3'd1: pp_add = 128'(prod_q[63:0]);
			3'd2, 3'd3: pp_add = 128'(prod_q[63:0]) << 32;
			3'd4: pp_add = 128'(prod_q[63:0]) << 64;
			default: pp_add = '0;
		endcase
	end

	assign div_start = (st_q == S_D1) || (st_q == S_BD);
	assign div_num = num_q;
	assign div_den = (st_q == S_D1) ? d1_q : 64'(prod_q[63:0] + hh_q);

	lsa_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(div_num),
		.den(div_den),
		.busy(div_busy),
		.done(div_done),
		.quo(div_quo)
	);

	assign tmag = (div_quo[127:63] != '0) ? 64'h7FFFFFFFFFFFFFFF : div_quo[63:0];
	assign term = it_q.weight[31] ? -$signed(tmag) : $signed(tmag);
	assign old = vld_q[k_q] ? $signed(ram_rdata) : 64'sd0;
	assign s65 = 65'(old) + 65'(term);
	assign ram_wdata = (s65 > 65'sh7FFFFFFFFFFFFFFF) ? 64'h7FFFFFFFFFFFFFFF :
		(s65 < -65'sh8000000000000000) ? 64'h8000000000000000 : s65[63:0];
	assign ram_we = (st_q == S_BW) && div_done;
	assign ram_re = (st_q == S_BD) || (rd_q && rd_in_range);
	assign ram_raddr = (st_q == S_BD) ? k_q : rd_addr;

	lsa_ram #(.WIDTH(64), .DEPTH(NUM_BINS)) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(k_q),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign req_pop = (st_q == S_IDLE) && !rd_q && !rd2_q && req.valid;
	assign res_load = rd2_q && (!out_vld_q || pop);
	assign empty = !out_vld_q;
	assign result = out_q;

	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
		if (req_pop)
			it_q <= req.item;
		unique case (st_q)
			S_M2: a_q <= sat32(66'(cfg.incident_energy) - (prod_q >>> 16));
			S_M3: d_q <= sat32(prod_q >>> 16);
			S_M4: d1_q <= prod_q[63:0];
			S_M5: d1_q <= d1_q + prod_q[63:0];
			S_M6: hh_q <= prod_q[63:0];
			S_M7: begin
				p_q <= prod_q[62:0];
				num_q <= '0;
			end
			S_PP: num_q <= num_q + pp_add;
			S_D1W: if (div_done) num_q <= div_quo;
			default: ;
		endcase
		if (res_load) begin
			out_q.bin_sum <= (rd_in_range && vld_q[rd_addr]) ? $signed(ram_rdata) : 64'sd0;
			out_q.loss_energy <= !rd_in_range ? 32'd0 :
				(loss_full[37:32] != '0) ? 32'hFFFFFFFF : loss_full[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			rd_q <= 1'b0;
			rd2_q <= 1'b0;
			pp_q <= '0;
			k_q <= '0;
			kstep_q <= '0;
			vld_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			rd_q <= 1'b0;
			if (rd_q)
				rd2_q <= 1'b1;
			if (res_load)
				rd2_q <= 1'b0;
			if (res_load)
				out_vld_q <= 1'b1;
			else if (pop)
				out_vld_q <= 1'b0;
			if (ram_we)
				vld_q[k_q] <= 1'b1;
			unique case (st_q)
				S_IDLE: begin
					if (req_pop) begin
						if (req.item.command == CMD_READ)
							rd_q <= 1'b1;
						else if (req.item.weight != '0)
							st_q <= S_M1;
					end
				end
				S_M1: st_q <= S_M2;
				S_M2: st_q <= S_M3;
				S_M3: st_q <= S_M4;
				S_M4: st_q <= S_M5;
				S_M5: st_q <= S_M6;
				S_M6: st_q <= S_M7;
				S_M7: begin
					pp_q <= '0;
					st_q <= S_PP;
				end
				S_PP: begin
					pp_q <= pp_q + 3'd1;
					if (pp_q == 3'd4)
						st_q <= S_D1;
				end
				S_D1: st_q <= S_D1W;
				S_D1W: begin
					if (div_done) begin
						k_q <= '0;
						kstep_q <= '0;
						st_q <= S_BE;
					end
				end
				S_BE: st_q <= S_BD;
				S_BD: st_q <= S_BW;
				S_BW: begin
					if (div_done) begin
						kstep_q <= kstep_q + 42'(cfg.bin_step);
						if (k_q == AW'(NUM_BINS - 1))
							st_q <= S_IDLE;
						else begin
							k_q <= k_q + AW'(1);
							st_q <= S_BE;
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy) else $error("divider started while busy");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (!out_vld_q || pop)) else $error("result overwritten");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_pop |-> (st_q == S_IDLE) && !rd2_q) else $error("request taken while busy");
	a_wr_bin: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> $past(st_q == S_BW) || $past(st_q == S_BD)) else $error("stray bin write");
endmodule
`default_nettype wire

[design/lorentzian_spectrum_accumulator_core.sv]
// Lorentzian spectrum accumulator: top level with configuration registers.
// Depends on lsa_pkg, lsa_front and lsa_back.
//
// Input channel: item is taken when push is high and full is low; a two-entry
// queue sits in front of the compute engine. Results: while empty is low the
// oldest read result is on result, and pop takes it.
// A read request (command 1) loads one bin sum and its loss energy into the
// result register after its bin is read, once that register is free; no
// request leaves the queue until it is loaded. An accumulate request
// (command 0) with nonzero weight yields no result and occupies the engine:
// after a first division, each bin takes one 128-by-64 bit division in the
// shared divider, which retires two quotient bits per cycle. When the receiver
// stalls, one result is held; a later read waits in the engine and the input
// queue fills, raising full. Reset clears the queues, the state and all bins
// (per-bin valid flags); configuration registers return to their defaults.
// Registers are written via cfg_we/cfg_index/cfg_data; the user must write them
// only while the block is idle, which the block itself does not enforce.
`default_nettype none
module lorentzian_spectrum_accumulator_core import lsa_pkg::*; #(
	parameter int NUM_BINS = NUM_BINS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire item_t item,
	output logic empty,
	input wire logic pop,
	output result_t result,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data
);
	cfg_t cfg_q;
	req_t req;
	logic req_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.incident_energy <= '0;
			cfg_q.core_broadening <= 31'd65536;
			cfg_q.final_broadening <= 31'd65536;
			cfg_q.energy_scale <= 32'sd65536;
			cfg_q.bin_step <= 31'd3972;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_INCIDENT: cfg_q.incident_energy <= cfg_data;
				CFG_CORE_BRD: cfg_q.core_broadening <= cfg_data[30:0];
				CFG_FINAL_BRD: cfg_q.final_broadening <= cfg_data[30:0];
				CFG_SCALE: cfg_q.energy_scale <= cfg_data;
				CFG_STEP: cfg_q.bin_step <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	lsa_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.req(req),
		.req_pop(req_pop)
	);

	lsa_back #(.NUM_BINS(NUM_BINS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.req(req),
		.req_pop(req_pop),
		.empty(empty),
		.pop(pop),
		.result(result)
	);
endmodule
`default_nettype wire
